// File: src/rgbo_pkg.sv
package rgbo_pkg;

   localparam int CHAN_W     = 8;
   localparam int PROD_W     = 2 * CHAN_W;
   localparam int NUM_W      = PROD_W + 1;
   localparam int WIDE_W     = 3 * CHAN_W;
   localparam int QUO_W      = CHAN_W;
   localparam int STEP_BITS  = 2;
   localparam int DIV_STAGES = QUO_W / STEP_BITS;
   localparam int FRONT_REGS = 3;
   localparam int LATENCY    = FRONT_REGS + DIV_STAGES;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

   // ceil(2^31 / 255); exact floor(x/255) for every x below 2^24
   localparam logic [47:0] RECIP_255 = 48'd8421505;

   typedef enum logic [1:0] {
      FUNC_OVER      = 2'd0,
      FUNC_COPY      = 2'd1,
      FUNC_TINT_OVER = 2'd2,
      FUNC_TINT_COPY = 2'd3
   } func_type;

   localparam logic [1:0] REG_TINT_RED   = 2'd0;
   localparam logic [1:0] REG_TINT_GREEN = 2'd1;
   localparam logic [1:0] REG_TINT_BLUE  = 2'd2;
   localparam logic [1:0] REG_TINT_ALPHA = 2'd3;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } tint_type;

   function automatic logic [PROD_W-1:0] div255(input logic [WIDE_W-1:0] x);
      logic [47:0] prod;
      prod = {24'd0, x} * RECIP_255;
      return prod[46:31];
   endfunction

endpackage

// File: src/rgbo_csr.sv
module rgbo_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rgbo_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rgbo_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rgbo_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output rgbo_pkg::tint_type            tint
);
   import rgbo_pkg::*;

   tint_type   tint_ff;
   tint_type   tint_in;
   logic [1:0] reg_sel;
   logic       wr_en;

   assign reg_sel = paddr[3:2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_comb begin
      tint_in = tint_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_TINT_RED:   tint_in.red   = pwdata[CHAN_W-1:0];
            REG_TINT_GREEN: tint_in.green = pwdata[CHAN_W-1:0];
            REG_TINT_BLUE:  tint_in.blue  = pwdata[CHAN_W-1:0];
            REG_TINT_ALPHA: tint_in.alpha = pwdata[CHAN_W-1:0];
            default:        tint_in = tint_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_ff.red   <= '0;
         tint_ff.green <= '0;
         tint_ff.blue  <= '0;
         tint_ff.alpha <= CHAN_MAX;
      end else begin
         tint_ff <= tint_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_TINT_RED:   prdata = {24'd0, tint_ff.red};
         REG_TINT_GREEN: prdata = {24'd0, tint_ff.green};
         REG_TINT_BLUE:  prdata = {24'd0, tint_ff.blue};
         REG_TINT_ALPHA: prdata = {24'd0, tint_ff.alpha};
         default:        prdata = '0;
      endcase
   end

   assign tint = tint_ff;

endmodule

// File: src/rgbo_alpha.sv
module rgbo_alpha (
   input  logic                       clock,
   input  logic                       en,
   input  rgbo_pkg::func_type         func,
   input  logic [rgbo_pkg::CHAN_W-1:0] bg_alpha,
   input  logic [rgbo_pkg::CHAN_W-1:0] fg_alpha,
   input  logic [rgbo_pkg::CHAN_W-1:0] tint_alpha,
   output logic [rgbo_pkg::CHAN_W-1:0] over_alpha,
   output logic [rgbo_pkg::CHAN_W-1:0] out_alpha
);
   import rgbo_pkg::*;

   localparam int TAIL = LATENCY - 4;

   // stage 1: products
   logic [PROD_W-1:0] abaf_ff, taaf_ff;
   logic [CHAN_W:0]   sum_ff;
   logic [CHAN_W-1:0] af1_ff;
   func_type          func1_ff;
   // stage 2: combined alpha
   logic [CHAN_W-1:0] oa2_ff, tcopy2_ff, af2_ff;
   func_type          func2_ff;
   // stage 3: tint scaling product
   logic [PROD_W-1:0] oata_ff;
   logic [CHAN_W-1:0] oa3_ff, tcopy3_ff, af3_ff;
   func_type          func3_ff;
   // stage 4 and delay to line up with the colour divider
   logic [CHAN_W-1:0] alpha_ff [TAIL+1];
   logic [CHAN_W-1:0] alpha_in;

   logic [PROD_W-1:0] abaf_div, taaf_div, oata_div;
   logic [CHAN_W+1:0] diff;
   logic [CHAN_W-1:0] oa_in;

   assign abaf_div = div255({8'd0, abaf_ff});
   assign taaf_div = div255({8'd0, taaf_ff});
   assign oata_div = div255({8'd0, oata_ff});

   assign diff  = {1'b0, sum_ff} - {1'b0, abaf_div[CHAN_W:0]};
   assign oa_in = (diff > {2'b0, CHAN_MAX}) ? CHAN_MAX : diff[CHAN_W-1:0];

   always_comb begin
      case (func3_ff)
         FUNC_OVER:      alpha_in = oa3_ff;
         FUNC_COPY:      alpha_in = af3_ff;
         FUNC_TINT_OVER: alpha_in = oata_div[CHAN_W-1:0];
         FUNC_TINT_COPY: alpha_in = tcopy3_ff;
         default:        alpha_in = oa3_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         abaf_ff   <= bg_alpha * fg_alpha;
         taaf_ff   <= tint_alpha * fg_alpha;
         sum_ff    <= {1'b0, bg_alpha} + {1'b0, fg_alpha};
         af1_ff    <= fg_alpha;
         func1_ff  <= func;

         oa2_ff    <= oa_in;
         tcopy2_ff <= taaf_div[CHAN_W-1:0];
         af2_ff    <= af1_ff;
         func2_ff  <= func1_ff;

         oata_ff   <= oa2_ff * tint_alpha;
         oa3_ff    <= oa2_ff;
         tcopy3_ff <= tcopy2_ff;
         af3_ff    <= af2_ff;
         func3_ff  <= func2_ff;

         alpha_ff[0] <= alpha_in;
         for (int i = 1; i <= TAIL; i++) begin
            alpha_ff[i] <= alpha_ff[i-1];
         end
      end
   end

   assign over_alpha = oa2_ff;
   assign out_alpha  = alpha_ff[TAIL];

endmodule

// File: src/rgbo_chan.sv
module rgbo_chan (
   input  logic                        clock,
   input  logic                        en,
   input  logic                        copy,
   input  logic [rgbo_pkg::CHAN_W-1:0] bg_color,
   input  logic [rgbo_pkg::CHAN_W-1:0] bg_alpha,
   input  logic [rgbo_pkg::CHAN_W-1:0] fg_color,
   input  logic [rgbo_pkg::CHAN_W-1:0] fg_alpha,
   input  logic [rgbo_pkg::CHAN_W-1:0] over_alpha,
   output logic [rgbo_pkg::CHAN_W-1:0] out_color
);
   import rgbo_pkg::*;

   typedef struct packed {
      logic [NUM_W-1:0]  rem;
      logic [QUO_W-1:0]  quo;
      logic [CHAN_W-1:0] oa;
      logic [CHAN_W-1:0] cf;
      logic              sat;
      logic              zero;
      logic              copy;
   } div_type;

   // stage 1
   logic [PROD_W-1:0] cfaf1_ff, cbab1_ff;
   logic [CHAN_W-1:0] inv1_ff, cf1_ff;
   logic              copy1_ff;
   // stage 2
   logic [WIDE_W-1:0] t2_ff;
   logic [PROD_W-1:0] cfaf2_ff;
   logic [CHAN_W-1:0] cf2_ff;
   logic              copy2_ff;
   // stage 3: numerator and divisor
   logic [NUM_W-1:0]  num3_ff;
   logic [CHAN_W-1:0] oa3_ff, cf3_ff;
   logic              copy3_ff;
   // divider stages, STEP_BITS quotient bits each
   div_type           div_ff [DIV_STAGES];
   div_type           div_in [DIV_STAGES];
   div_type           div_src [DIV_STAGES];
   div_type           last;

   always_comb begin
      div_src[0].rem  = num3_ff;
      div_src[0].quo  = '0;
      div_src[0].oa   = oa3_ff;
      div_src[0].cf   = cf3_ff;
      // quotient would not fit in eight bits
      div_src[0].sat  = num3_ff >= {1'b0, oa3_ff, 8'd0};
      div_src[0].zero = (oa3_ff == '0);
      div_src[0].copy = copy3_ff;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      if (k > 0) begin : g_link
         assign div_src[k] = div_ff[k-1];
      end

      always_comb begin
         logic [NUM_W-1:0] dv;
         div_in[k] = div_src[k];
         for (int j = 0; j < STEP_BITS; j++) begin
            dv = {{(NUM_W-CHAN_W){1'b0}}, div_in[k].oa} << (QUO_W - 1 - STEP_BITS*k - j);
            if (div_in[k].rem >= dv) begin
               div_in[k].rem = div_in[k].rem - dv;
               div_in[k].quo[QUO_W - 1 - STEP_BITS*k - j] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cfaf1_ff <= fg_color * fg_alpha;
         cbab1_ff <= bg_color * bg_alpha;
         inv1_ff  <= CHAN_MAX - fg_alpha;
         cf1_ff   <= fg_color;
         copy1_ff <= copy;

         t2_ff    <= cbab1_ff * inv1_ff;
         cfaf2_ff <= cfaf1_ff;
         cf2_ff   <= cf1_ff;
         copy2_ff <= copy1_ff;

         num3_ff  <= {1'b0, cfaf2_ff} + {1'b0, div255(t2_ff)};
         oa3_ff   <= over_alpha;
         cf3_ff   <= cf2_ff;
         copy3_ff <= copy2_ff;
      end
   end

   assign last = div_ff[DIV_STAGES-1];

   always_comb begin
      if (last.copy || last.zero) begin
         out_color = last.cf;
      end else if (last.sat) begin
         out_color = CHAN_MAX;
      end else begin
         out_color = last.quo;
      end
   end

endmodule

// File: src/rgba_alpha_over_blend_unit.sv
// Pixel over/copy/tint compositor.
// Datapath from request accept to result valid: 3 multiply/scale
// stages, then a 4-stage divider retiring 2 quotient bits per stage.
// Throughput: one pixel pair per cycle; a stalled result holds the pipe.
// Reset (synchronous, active high) empties the pipeline and sets the tint
// registers to red/green/blue 0, alpha 255.
module rgba_alpha_over_blend_unit (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // bg_red, bg_green, bg_blue, bg_alpha,
                                   // fg_red, fg_green, fg_blue, fg_alpha
   input  logic [1:0]  req_tuser,  // func
   // result
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // out_red, out_green, out_blue, out_alpha
   // configuration
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rgbo_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rgbo_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rgbo_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rgbo_pkg::*;

   tint_type          tint;
   func_type          func;
   logic              en;
   logic              valid_ff [LATENCY];
   logic [CHAN_W-1:0] bg [3];
   logic [CHAN_W-1:0] fg [3];
   logic [CHAN_W-1:0] tint_rgb [3];
   logic [CHAN_W-1:0] cf [3];
   logic [CHAN_W-1:0] res [3];
   logic [CHAN_W-1:0] bg_alpha, fg_alpha, over_alpha, out_alpha;

   rgbo_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .tint    (tint)
   );

   // whole pipe advances unless the output holds an untaken result
   assign en         = !valid_ff[LATENCY-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = valid_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LATENCY; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= req_tvalid;
         for (int i = 1; i < LATENCY; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   assign func     = func_type'(req_tuser);
   assign bg_alpha = req_tdata[31:24];
   assign fg_alpha = req_tdata[63:56];
   assign tint_rgb[0] = tint.red;
   assign tint_rgb[1] = tint.green;
   assign tint_rgb[2] = tint.blue;

   rgbo_alpha u_alpha (
      .clock      (clock),
      .en         (en),
      .func       (func),
      .bg_alpha   (bg_alpha),
      .fg_alpha   (fg_alpha),
      .tint_alpha (tint.alpha),
      .over_alpha (over_alpha),
      .out_alpha  (out_alpha)
   );

   for (genvar c = 0; c < 3; c++) begin : g_chan
      assign bg[c] = req_tdata[CHAN_W*c +: CHAN_W];
      assign fg[c] = req_tdata[CHAN_W*(c+4) +: CHAN_W];
      // tint modes substitute the tint colour for the foreground
      assign cf[c] = req_tuser[1] ? tint_rgb[c] : fg[c];

      rgbo_chan u_chan (
         .clock      (clock),
         .en         (en),
         .copy       (req_tuser[0]),
         .bg_color   (bg[c]),
         .bg_alpha   (bg_alpha),
         .fg_color   (cf[c]),
         .fg_alpha   (fg_alpha),
         .over_alpha (over_alpha),
         .out_color  (res[c])
      );
   end

   assign rsp_tdata = {out_alpha, res[2], res[1], res[0]};

endmodule
